// ===== rtl/core/i2d_pkg.sv =====
// i2d_pkg: widths and character codes shared by the int64 to decimal text block
// no dependencies; imported by the channel interfaces and every module
package i2d_pkg;

  localparam int MAG_W      = 64;
  localparam int CAP_W      = 8;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int ITER_W     = $clog2(MAG_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(MAG_W - 1);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

endpackage

// ===== rtl/core/i2d_item_if.sv =====
// i2d_item_if: request channel carrying one signed value and a buffer capacity
// depends on i2d_pkg
interface i2d_item_if
  import i2d_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [MAG_W-1:0]  value;
  logic        [CAP_W-1:0]  capacity;

  modport source (output valid, output value, output capacity, input ready);
  modport sink   (input valid, input value, input capacity, output ready);
endinterface

// ===== rtl/core/i2d_text_if.sv =====
// i2d_text_if: result channel carrying one text character per transfer
// depends on i2d_pkg
interface i2d_text_if
  import i2d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              accepted;
  logic [LEN_W-1:0]  text_length;

  modport source (output valid, output character, output last, output accepted,
                  output text_length, input ready);
  modport sink   (input valid, input character, input last, input accepted,
                  input text_length, output ready);
endinterface

// ===== rtl/core/i2d_dabble_step.sv =====
// i2d_dabble_step: one shift-and-add-3 step of binary to bcd conversion
// depends on i2d_pkg
module i2d_dabble_step
  import i2d_pkg::*;
(
  input  logic [BCD_W-1:0] bcd,
  input  logic [MAG_W-1:0] bin,
  output logic [BCD_W-1:0] bcd_next,
  output logic [MAG_W-1:0] bin_next
);

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  assign bcd_next = {adj[BCD_W-2:0], bin[MAG_W-1]};
  assign bin_next = {bin[MAG_W-2:0], 1'b0};

endmodule

// ===== rtl/core/int64_to_decimal_ascii_top.sv =====
// int64_to_decimal_ascii_top: signed 64-bit integer to decimal ascii text
// depends on i2d_pkg, i2d_item_if, i2d_text_if, i2d_dabble_step
//
// usage
//   item channel: one request holds a signed 64-bit value and a capacity
//   text channel: characters leave most significant first, an optional '-'
//     then the digits; last marks the final one, every character carries
//     the whole text length; if the text length is not below the capacity
//     a single reject result (character 0, last 1, accepted 0, length 0)
//     is sent instead
//   timing: after a request is taken the shared shift-add-3 unit takes one
//     magnitude bit per step in ST_CONV, ST_SIZE then sizes the text, then
//     ST_EMIT loads one character per cycle while the output register is free;
//     a new request is taken only once the item is done, back in ST_IDLE
//   item ready is high only between items; the last character may still
//     wait in the output register while the next request is taken
//   a stalled receiver simply holds the output register and the sequencer
//   reset (rst, synchronous) returns to idle and drops any pending result
module int64_to_decimal_ascii_top
  import i2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2d_item_if.sink   item,
  i2d_text_if.source text
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t state;

  // conversion registers
  logic [MAG_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [ITER_W-1:0] iter;
  logic [CAP_W-1:0]  cap;
  logic              neg;

  // emit registers
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len;
  logic              sign_pend;
  logic              reject;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_acc;
  logic [LEN_W-1:0]  out_len;

  logic [BCD_W-1:0]  bcd_next;
  logic [MAG_W-1:0]  bin_next;
  logic [LEN_W-1:0]  nd_calc;
  logic [LEN_W-1:0]  len_calc;
  logic [3:0]        digit_sel;
  logic              slot_free;
  logic              take;

  i2d_dabble_step u_step (
    .bcd      (bcd),
    .bin      (bin),
    .bcd_next (bcd_next),
    .bin_next (bin_next)
  );

  // digit count: position of the highest non-zero bcd digit, at least one
  always_comb begin
    nd_calc = LEN_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        nd_calc = LEN_W'(i + 1);
      end
    end
  end

  assign len_calc  = nd_calc + LEN_W'(neg);
  assign digit_sel = bcd[{idx, 2'b00} +: 4];
  assign slot_free = !out_valid || text.ready;
  assign take      = item.valid && item.ready;

  assign item.ready       = (state == ST_IDLE);
  assign text.valid       = out_valid;
  assign text.character   = out_char;
  assign text.last        = out_last;
  assign text.accepted    = out_acc;
  assign text.text_length = out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
      sign_pend <= 1'b0;
      reject    <= 1'b0;
    end else begin
      // while emitting, the emit branch below refills the output register
      if (out_valid && text.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            neg   <= item.value[MAG_W-1];
            // two's complement negation also covers the most negative value
            bin   <= item.value[MAG_W-1] ? (~item.value + MAG_W'(1)) : item.value;
            cap   <= item.capacity;
            bcd   <= '0;
            iter  <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd  <= bcd_next;
          bin  <= bin_next;
          iter <= iter + ITER_W'(1);
          if (iter == ITER_LAST) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          len       <= len_calc;
          idx       <= IDX_W'(nd_calc - LEN_W'(1));
          sign_pend <= neg;
          reject    <= ({3'b000, len_calc} >= cap);
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (reject) begin
              out_char <= CHAR_NONE;
              out_last <= 1'b1;
              out_acc  <= 1'b0;
              out_len  <= '0;
              state    <= ST_IDLE;
            end else if (sign_pend) begin
              out_char  <= CHAR_MINUS;
              out_last  <= (len == LEN_W'(1));
              out_acc   <= 1'b1;
              out_len   <= len;
              sign_pend <= 1'b0;
            end else begin
              out_char <= CHAR_ZERO + {4'b0000, digit_sel};
              out_last <= (idx == '0);
              out_acc  <= 1'b1;
              out_len  <= len;
              if (idx == '0) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx - IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a taken request keeps the block busy for the following cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !item.ready)
    else $error("item ready straight after a request was taken");

  // a reject result is always a lone final result with zero length
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    text.valid && !text.accepted |-> text.last && (text.text_length == '0))
    else $error("malformed reject result");

  // accepted characters are a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.accepted |->
      (text.character == CHAR_MINUS) ||
      ((text.character >= CHAR_ZERO) && (text.character <= CHAR_NINE)))
    else $error("character outside the decimal set");

  // the text length never exceeds twenty characters nor is zero when accepted
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.accepted |->
      (text.text_length != '0) && (text.text_length <= LEN_W'(NUM_DIGITS)))
    else $error("text length out of range");

endmodule

// ===== test/int64_to_decimal_ascii_top_tb.sv =====
`timescale 1ns / 1ps
// int64_to_decimal_ascii_top_tb: self-checking bench for the int64 to decimal text block
// depends on i2d_pkg, i2d_item_if, i2d_text_if and int64_to_decimal_ascii_top
module int64_to_decimal_ascii_top_tb
  import i2d_pkg::*;
();

  localparam int NUM_DIRECTED  = 23;
  localparam int NUM_PRESSURE  = 8;
  localparam int NUM_RANDOM    = 399;
  localparam int NUM_QUIET     = 40;
  localparam int LONG_HOLD     = 500;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 120;

  localparam logic signed [MAG_W-1:0] MOST_NEGATIVE = 64'sh8000_0000_0000_0000;
  localparam logic signed [MAG_W-1:0] MOST_POSITIVE = 64'sh7FFF_FFFF_FFFF_FFFF;

  // one character of text as it should leave the block
  typedef struct {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              accepted;
    logic [LEN_W-1:0]  text_length;
  } text_char_t;

  // directed request; typed rows carry the text to expect ("" means rejected)
  typedef struct {
    logic signed [MAG_W-1:0] value;
    logic [CAP_W-1:0]        capacity;
    bit                      typed;
    string                   text;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;

  i2d_item_if item_ch ();
  i2d_text_if text_ch ();

  int64_to_decimal_ascii_top DUT (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .text (text_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_char_t pending_text[$];   // characters still owed by the block, oldest first
  int         mismatches = 0;
  bit         idling_on = 1'b0;
  bit         long_hold_pending = 1'b0;

  // extremes, zero, boundaries of the capacity test and wide bit patterns
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{64'sd0,                 8'd2,   1'b1, "0"},
    '{64'sd0,                 8'd1,   1'b1, ""},
    '{64'sd0,                 8'd0,   1'b1, ""},
    '{MOST_POSITIVE,          8'd20,  1'b1, "9223372036854775807"},
    '{MOST_POSITIVE,          8'd19,  1'b1, ""},
    '{MOST_NEGATIVE,          8'd21,  1'b1, "-9223372036854775808"},
    '{MOST_NEGATIVE,          8'd20,  1'b1, ""},
    '{MOST_NEGATIVE,          8'd255, 1'b1, "-9223372036854775808"},
    '{-64'sd1,                8'd3,   1'b1, "-1"},
    '{-64'sd1,                8'd2,   1'b1, ""},
    '{-64'sd1,                8'd0,   1'b1, ""},
    '{64'sd1,                 8'd255, 1'b1, "1"},
    '{64'sd9,                 8'd2,   1'b1, "9"},
    '{64'sd10,                8'd3,   1'b0, ""},
    '{-64'sd10,               8'd4,   1'b0, ""},
    '{64'sd1000000000000,     8'd14,  1'b0, ""},
    '{64'sd100000000,         8'd10,  1'b0, ""},
    '{64'sd999999999999,      8'd13,  1'b0, ""},
    '{-64'sd999999999999,     8'd13,  1'b0, ""},
    '{64'sh8000_0000_0000_0001, 8'd21, 1'b0, ""},
    '{64'sh5555_5555_5555_5555, 8'd255, 1'b0, ""},
    '{64'shAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b0, ""},
    '{64'sd1234567890,        8'd127, 1'b0, ""}
  };

  // the single result sent when the text does not fit
  function automatic void push_reject();
    text_char_t c;
    c.character   = CHAR_NONE;
    c.last        = 1'b1;
    c.accepted    = 1'b0;
    c.text_length = '0;
    pending_text.push_back(c);
  endfunction

  // expected characters written out by hand for the directed rows
  function automatic void push_typed_text(string s);
    text_char_t c;
    if (s.len() == 0) begin
      push_reject();
    end else begin
      for (int i = 0; i < s.len(); i++) begin
        c.character   = s[i];
        c.last        = (i == s.len() - 1);
        c.accepted    = 1'b1;
        c.text_length = LEN_W'(s.len());
        pending_text.push_back(c);
      end
    end
  endfunction

  // decimal text of a signed value, or a reject when it will not fit the capacity
  function automatic void format_decimal(logic signed [MAG_W-1:0] v, logic [CAP_W-1:0] cap);
    logic [MAG_W-1:0]  magnitude;
    logic [3:0]        digits [NUM_DIGITS];
    int                n;
    int                text_len;
    bit                negative;
    text_char_t        c;
    negative  = v[MAG_W-1];
    // two's complement negation also gives the right magnitude for the most negative value
    magnitude = negative ? (~v + 64'd1) : v;
    n = 0;
    do begin
      digits[n] = 4'(magnitude % 64'd10);
      magnitude = magnitude / 64'd10;
      n++;
    end while (magnitude != 0 && n < NUM_DIGITS);
    text_len = n + (negative ? 1 : 0);
    if (text_len >= int'(cap)) begin
      push_reject();
    end else begin
      c.accepted    = 1'b1;
      c.text_length = LEN_W'(text_len);
      if (negative) begin
        c.character = CHAR_MINUS;
        c.last      = 1'b0;
        pending_text.push_back(c);
      end
      // most significant digit first
      for (int i = n - 1; i >= 0; i--) begin
        c.character = CHAR_ZERO + CHAR_W'(digits[i]);
        c.last      = (i == 0);
        pending_text.push_back(c);
      end
    end
  endfunction

  // characters in the text of v, sign included
  function automatic int decimal_length(logic signed [MAG_W-1:0] v);
    logic [MAG_W-1:0] magnitude;
    int               n;
    magnitude = v[MAG_W-1] ? (~v + 64'd1) : v;
    n = 0;
    do begin
      magnitude = magnitude / 64'd10;
      n++;
    end while (magnitude != 0);
    return n + (v[MAG_W-1] ? 1 : 0);
  endfunction

  function automatic logic [MAG_W-1:0] ten_to(int n);
    logic [MAG_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // values spread over every text length, with the extremes now and then
  function automatic logic signed [MAG_W-1:0] random_value();
    logic [MAG_W-1:0] raw;
    int               pick;
    pick = $urandom_range(0, 19);
    raw  = {$urandom, $urandom};
    case (pick)
      0: return MOST_NEGATIVE;
      1: return MOST_POSITIVE;
      2: return '0;
      3, 4: return raw;
      default: begin
        raw = raw % ten_to($urandom_range(1, 19));
        if ($urandom_range(0, 1) == 1) raw = ~raw + 64'd1;
        return raw;
      end
    endcase
  endfunction

  // mostly fitting capacities, with the reject boundary hit often
  function automatic logic [CAP_W-1:0] random_capacity(logic signed [MAG_W-1:0] v);
    int text_len;
    int pick;
    text_len = decimal_length(v);
    pick     = $urandom_range(0, 9);
    case (pick)
      0:       return CAP_W'(text_len);
      1:       return CAP_W'($urandom_range(0, text_len));
      2, 3:    return CAP_W'($urandom_range(0, 255));
      default: return CAP_W'($urandom_range(text_len + 1, text_len + 4));
    endcase
  endfunction

  // offer one request, with an optional gap first, and log what it should produce
  task automatic offer_request(logic signed [MAG_W-1:0] v, logic [CAP_W-1:0] cap,
                               bit typed = 1'b0, string text = "");
    if (idling_on && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.value    <= v;
    item_ch.capacity <= cap;
    do @(posedge clk); while (!item_ch.ready);
    // request taken at this edge
    if (typed) push_typed_text(text);
    else format_decimal(v, cap);
  endtask

  // sender pauses until every owed character has come out
  task automatic drain_text();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_text.size() != 0);
  endtask

  // receiver: random stall bursts, plus one long hold-off counted here
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        text_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        text_ch.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        // a stall burst starts here; stall_left holds the rest of the burst
        text_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        text_ch.ready <= 1'b1;
      end
    end
  end

  // checker: every accepted character against the oldest one owed
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (pending_text.size() == 0) begin
        $error("character: nothing expected, got %0h", text_ch.character);
        mismatches++;
      end else begin
        want = pending_text.pop_front();
        if (text_ch.character !== want.character) begin
          $error("character: expected %0h, got %0h", want.character, text_ch.character);
          mismatches++;
        end
        if (text_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, text_ch.last);
          mismatches++;
        end
        if (text_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, text_ch.accepted);
          mismatches++;
        end
        if (text_ch.text_length !== want.text_length) begin
          $error("text_length: expected %0d, got %0d", want.text_length, text_ch.text_length);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no request or character moving ends the run
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (text_ch.valid && text_ch.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // main sequence
  initial begin
    logic signed [MAG_W-1:0] v;
    rst              = 1'b1;
    item_ch.valid    = 1'b0;
    item_ch.value    = '0;
    item_ch.capacity = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    idling_on = 1'b1;

    // directed table
    foreach (directed_rows[i])
      offer_request(directed_rows[i].value, directed_rows[i].capacity,
                    directed_rows[i].typed, directed_rows[i].text);
    drain_text();

    // receiver holds off while requests keep coming, so the block backs up
    long_hold_pending = 1'b1;
    for (int i = 0; i < NUM_PRESSURE; i++) begin
      v = random_value();
      offer_request(v, random_capacity(v));
    end
    drain_text();

    // random part with idling on both sides, emptying out now and then
    for (int i = 0; i < NUM_RANDOM; i++) begin
      v = random_value();
      offer_request(v, random_capacity(v));
      if (i % 100 == 99) drain_text();
    end

    // closing stretch at full rate
    idling_on = 1'b0;
    for (int i = 0; i < NUM_QUIET; i++) begin
      v = random_value();
      offer_request(v, random_capacity(v));
    end
    drain_text();

    // settling wait to catch any stray character
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_text.size() != 0)
      $error("text: %0d characters never arrived", pending_text.size());
    if (mismatches == 0 && pending_text.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/i2d_pkg.sv
rtl/core/i2d_item_if.sv
rtl/core/i2d_text_if.sv
rtl/core/i2d_dabble_step.sv
rtl/core/int64_to_decimal_ascii_top.sv
test/int64_to_decimal_ascii_top_tb.sv
